// ===== design/shdh_pkg.sv =====
// ----------------------------------------------------------------------------
// shdh_pkg: shared types and constants for the double-hash substring compare
// Field widths, moduli, command codes, controller states and the
// command/status structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package shdh_pkg;

    // Hash arithmetic
    localparam int HASH_W = 30;
    localparam logic [HASH_W-1:0] PRIME_ONE  = 30'd1000000007;
    localparam logic [HASH_W-1:0] PRIME_TWO  = 30'd1000000009;
    localparam logic [HASH_W-1:0] BASE_RESET = 30'd31;

    // Default string capacity
    localparam int MAX_LEN_DEF = 1024;

    // Item fields
    localparam int CMD_W  = 2;
    localparam int CHAR_W = 8;
    localparam int POS_W  = 11;
    localparam int SUM_W  = POS_W + 1;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 8;

    // Configuration port
    localparam int APB_AW = 3;
    localparam logic [APB_AW-1:0] REG_BASE_ADDR = 3'd0;

    // Exponent bits of a window length, least significant first
    localparam logic [3:0] EXP_LAST_BIT = 4'(POS_W - 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 2'd0,
        CMD_QUERY  = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    // Which prefix a memory read fetches (also names the capture target)
    typedef enum logic [2:0] {
        RS_A_END   = 3'd0,
        RS_A_START = 3'd1,
        RS_B_END   = 3'd2,
        RS_B_START = 3'd3,
        RS_PREV    = 3'd4
    } rd_sel_t;

    localparam logic [2:0] RD_STEPS = 3'd4;

    typedef enum logic [2:0] {
        MUL_APPEND  = 3'd0,
        MUL_POW_ACC = 3'd1,
        MUL_POW_SQ  = 3'd2,
        MUL_WIN_A   = 3'd3,
        MUL_WIN_B   = 3'd4
    } mul_op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CLR,
        ST_AP_RD,
        ST_AP_GO,
        ST_AP_WAIT,
        ST_AP_WR,
        ST_Q_CHK,
        ST_Q_RD,
        ST_PW_BIT,
        ST_PA_GO,
        ST_PA_WAIT,
        ST_PS_GO,
        ST_PS_WAIT,
        ST_WA_GO,
        ST_WA_WAIT,
        ST_WB_GO,
        ST_WB_WAIT,
        ST_Q_OUT
    } state_t;

    typedef struct packed {
        logic    load_item;
        logic    cnt_clear;
        logic    app_write;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    cap_en;
        rd_sel_t cap_sel;
        logic    pow_init;
        logic    mul_start;
        mul_op_t mul_op;
        logic    mul_wr;
        logic    out_load;
        logic [3:0] bit_idx;
    } ctrl_t;

    typedef struct packed {
        cmd_t in_cmd;
        logic full;
        logic range_err;
        logic mul_done;
        logic exp_bit;
        logic out_free;
    } status_t;

endpackage

// ===== design/shdh_mulmod.sv =====
// ----------------------------------------------------------------------------
// shdh_mulmod: bit-serial modular multiplier
// Computes a*b mod p, one bit of b per cycle, most significant first.
// Operands must already be below p. Result is held until the next start.
// ----------------------------------------------------------------------------
module shdh_mulmod (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [shdh_pkg::HASH_W-1:0]   a,
    input  logic [shdh_pkg::HASH_W-1:0]   b,
    input  logic [shdh_pkg::HASH_W-1:0]   p,
    output logic                          done,
    output logic [shdh_pkg::HASH_W-1:0]   res
);
    import shdh_pkg::*;

    localparam logic [4:0] LAST_STEP = 5'(HASH_W - 1);

    logic [HASH_W-1:0] acc_reg, acc_next;
    logic [HASH_W-1:0] a_reg, b_reg;
    logic [4:0]        cnt_reg;
    logic              busy_reg, done_reg;

    logic [HASH_W:0]   dbl, dbl_red_w, add;
    logic [HASH_W-1:0] dbl_red;

    // One step: acc = 2*acc (mod p) + bit*a (mod p)
    always_comb begin
        dbl       = {acc_reg, 1'b0};
        dbl_red_w = (dbl >= {1'b0, p}) ? dbl - {1'b0, p} : dbl;
        dbl_red   = dbl_red_w[HASH_W-1:0];
        add       = {1'b0, dbl_red} + (b_reg[HASH_W-1] ? {1'b0, a_reg} : '0);
        acc_next  = (add >= {1'b0, p}) ? HASH_W'(add - {1'b0, p}) : add[HASH_W-1:0];
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operands and accumulator
    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg <= '0;
            a_reg   <= a;
            b_reg   <= b;
        end else if (busy_reg) begin
            acc_reg <= acc_next;
            b_reg   <= {b_reg[HASH_W-2:0], 1'b0};
        end
    end

    assign done = done_reg;
    assign res  = acc_reg;

endmodule

// ===== design/shdh_datapath.sv =====
// ----------------------------------------------------------------------------
// shdh_datapath: prefix hash stores, modular lanes and result register
// Two lanes, one per modulus, each with its prefix memory and multiplier.
// Also holds the base register, the loaded count and the item fields.
// ----------------------------------------------------------------------------
module shdh_datapath #(
    parameter int MAX_LEN = shdh_pkg::MAX_LEN_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input item
    input  logic [shdh_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  logic [shdh_pkg::CMD_W-1:0]         s_tuser,
    // result
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic                               m_equal,
    output logic                               m_range_error,
    // configuration
    input  logic                               cfg_we,
    input  logic [shdh_pkg::APB_AW-1:0]        cfg_addr,
    input  logic [31:0]                        cfg_wdata,
    output logic [31:0]                        cfg_rdata,
    // controller link
    input  shdh_pkg::ctrl_t                    ctrl,
    output shdh_pkg::status_t                  status
);
    import shdh_pkg::*;

    localparam int AW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam int CMP_W = (CNT_W > SUM_W) ? CNT_W : SUM_W;

    // Item fields
    logic [CHAR_W-1:0] ch_reg;
    logic [POS_W-1:0]  sa_reg, sb_reg, len_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [HASH_W-1:0] base_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.load_item) begin
            ch_reg  <= s_tdata[7:0];
            sa_reg  <= s_tdata[18:8];
            sb_reg  <= s_tdata[29:19];
            len_reg <= s_tdata[40:30];
        end
    end

    // Base register and loaded count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg  <= BASE_RESET;
            count_reg <= '0;
        end else begin
            if (cfg_we && cfg_addr == REG_BASE_ADDR)
                base_reg <= cfg_wdata[HASH_W-1:0];
            if (ctrl.cnt_clear)
                count_reg <= '0;
            else if (ctrl.app_write)
                count_reg <= count_reg + CNT_W'(1);
        end
    end

    assign cfg_rdata = (cfg_addr == REG_BASE_ADDR) ? {{(32-HASH_W){1'b0}}, base_reg} : '0;

    // Window ends and range check
    logic [CMP_W-1:0] end_a, end_b, cnt_ext, k_sel;
    assign end_a   = CMP_W'(sa_reg) + CMP_W'(len_reg);
    assign end_b   = CMP_W'(sb_reg) + CMP_W'(len_reg);
    assign cnt_ext = CMP_W'(count_reg);

    // Prefix length to read; entry k-1 holds prefix k
    always_comb begin
        case (ctrl.rd_sel)
            RS_A_END:   k_sel = end_a;
            RS_A_START: k_sel = CMP_W'(sa_reg);
            RS_B_END:   k_sel = end_b;
            RS_B_START: k_sel = CMP_W'(sb_reg);
            default:    k_sel = cnt_ext;
        endcase
    end

    logic [AW-1:0] rd_addr, wr_addr;
    logic          zero_reg;
    assign rd_addr = AW'(k_sel - CMP_W'(1));
    assign wr_addr = AW'(count_reg);

    always_ff @(posedge aclk) begin
        if (ctrl.rd_en)
            zero_reg <= (k_sel == '0);
    end

    logic [1:0] lane_eq;
    logic [1:0] lane_done;

    // Per-modulus lanes
    for (genvar i = 0; i < 2; i++) begin : g_lane
        logic [HASH_W-1:0] p_c, bmod;
        logic [HASH_W-1:0] mem [MAX_LEN];
        logic [HASH_W-1:0] rd_data_reg, rd_val;
        logic [HASH_W-1:0] pw_reg, bsq_reg, hia_reg, loa_reg, hib_reg, lob_reg;
        logic [HASH_W-1:0] mul_a, mul_b, mul_res, wr_val;
        logic [HASH_W:0]   app_sum;
        logic [HASH_W-1:0] da, db;
        logic              mul_done;

        assign p_c  = (i == 0) ? PRIME_ONE : PRIME_TWO;
        assign bmod = (base_reg >= p_c) ? base_reg - p_c : base_reg;

        // Prefix store
        always_ff @(posedge aclk) begin
            if (ctrl.app_write)
                mem[wr_addr] <= wr_val;
            if (ctrl.rd_en)
                rd_data_reg <= mem[rd_addr];
        end
        assign rd_val = zero_reg ? '0 : rd_data_reg;

        // Multiplier operands
        always_comb begin
            case (ctrl.mul_op)
                MUL_APPEND:  begin mul_a = bmod;    mul_b = rd_val;  end
                MUL_POW_ACC: begin mul_a = pw_reg;  mul_b = bsq_reg; end
                MUL_POW_SQ:  begin mul_a = bsq_reg; mul_b = bsq_reg; end
                MUL_WIN_A:   begin mul_a = pw_reg;  mul_b = loa_reg; end
                default:     begin mul_a = pw_reg;  mul_b = lob_reg; end
            endcase
        end

        shdh_mulmod u_mul (
            .aclk    (aclk),
            .aresetn (aresetn),
            .start   (ctrl.mul_start),
            .a       (mul_a),
            .b       (mul_b),
            .p       (p_c),
            .done    (mul_done),
            .res     (mul_res)
        );
        assign lane_done[i] = mul_done;

        // New prefix: base*prev + byte, reduced
        assign app_sum = {1'b0, mul_res} + (HASH_W+1)'(ch_reg);
        assign wr_val  = (app_sum >= {1'b0, p_c}) ? HASH_W'(app_sum - {1'b0, p_c})
                                                  : app_sum[HASH_W-1:0];

        // Power, prefixes and scaled prefixes
        always_ff @(posedge aclk) begin
            if (ctrl.pow_init) begin
                pw_reg  <= HASH_W'(1);
                bsq_reg <= bmod;
            end
            if (ctrl.cap_en) begin
                case (ctrl.cap_sel)
                    RS_A_END:   hia_reg <= rd_val;
                    RS_A_START: loa_reg <= rd_val;
                    RS_B_END:   hib_reg <= rd_val;
                    default:    lob_reg <= rd_val;
                endcase
            end
            if (ctrl.mul_wr) begin
                case (ctrl.mul_op)
                    MUL_POW_ACC: pw_reg  <= mul_res;
                    MUL_POW_SQ:  bsq_reg <= mul_res;
                    MUL_WIN_A:   loa_reg <= mul_res;
                    MUL_WIN_B:   lob_reg <= mul_res;
                    default:     ;
                endcase
            end
        end

        // Window hashes and compare
        assign da = (hia_reg >= loa_reg) ? hia_reg - loa_reg : hia_reg + (p_c - loa_reg);
        assign db = (hib_reg >= lob_reg) ? hib_reg - lob_reg : hib_reg + (p_c - lob_reg);
        assign lane_eq[i] = (da == db);
    end

    // Result register
    logic m_valid_reg, m_equal_reg, m_err_reg;
    logic out_free;
    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn)
            m_valid_reg <= 1'b0;
        else if (ctrl.out_load)
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.out_load) begin
            m_err_reg   <= status.range_err;
            m_equal_reg <= !status.range_err && (&lane_eq);
        end
    end

    assign m_tvalid      = m_valid_reg;
    assign m_equal       = m_equal_reg;
    assign m_range_error = m_err_reg;

    // Status to the controller
    always_comb begin
        status.in_cmd    = cmd_t'(s_tuser);
        status.full      = (count_reg == CNT_W'(MAX_LEN));
        status.range_err = (end_a > cnt_ext) || (end_b > cnt_ext);
        status.mul_done  = lane_done[0];
        status.exp_bit   = len_reg[ctrl.bit_idx];
        status.out_free  = out_free;
    end

endmodule

// ===== design/shdh_ctrl.sv =====
// ----------------------------------------------------------------------------
// shdh_ctrl: command sequencer
// Steps appends, clears and queries through the datapath: prefix reads,
// square-and-multiply over the length bits, window scaling and result load.
// ----------------------------------------------------------------------------
module shdh_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output shdh_pkg::ctrl_t      ctrl,
    input  shdh_pkg::status_t    status
);
    import shdh_pkg::*;

    state_t     state_reg, state_next;
    logic [3:0] bit_reg, bit_next;
    logic [2:0] rd_idx_reg, rd_idx_next;
    logic       accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            bit_reg    <= '0;
            rd_idx_reg <= '0;
        end else begin
            state_reg  <= state_next;
            bit_reg    <= bit_next;
            rd_idx_reg <= rd_idx_next;
        end
    end

    // Next state
    always_comb begin
        state_next  = state_reg;
        bit_next    = bit_reg;
        rd_idx_next = rd_idx_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (status.in_cmd)
                        CMD_APPEND: state_next = ST_AP_RD;
                        CMD_QUERY:  state_next = ST_Q_CHK;
                        CMD_CLEAR:  state_next = ST_CLR;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CLR:     state_next = ST_IDLE;
            ST_AP_RD:   state_next = status.full ? ST_IDLE : ST_AP_GO;
            ST_AP_GO:   state_next = ST_AP_WAIT;
            ST_AP_WAIT: if (status.mul_done) state_next = ST_AP_WR;
            ST_AP_WR:   state_next = ST_IDLE;
            ST_Q_CHK: begin
                bit_next    = '0;
                rd_idx_next = '0;
                state_next  = status.range_err ? ST_Q_OUT : ST_Q_RD;
            end
            ST_Q_RD: begin
                rd_idx_next = rd_idx_reg + 3'd1;
                if (rd_idx_reg == RD_STEPS)
                    state_next = ST_PW_BIT;
            end
            ST_PW_BIT:  state_next = status.exp_bit ? ST_PA_GO : ST_PS_GO;
            ST_PA_GO:   state_next = ST_PA_WAIT;
            ST_PA_WAIT: if (status.mul_done) state_next = ST_PS_GO;
            ST_PS_GO:   state_next = ST_PS_WAIT;
            ST_PS_WAIT: begin
                if (status.mul_done) begin
                    bit_next   = bit_reg + 4'd1;
                    state_next = (bit_reg == EXP_LAST_BIT) ? ST_WA_GO : ST_PW_BIT;
                end
            end
            ST_WA_GO:   state_next = ST_WA_WAIT;
            ST_WA_WAIT: if (status.mul_done) state_next = ST_WB_GO;
            ST_WB_GO:   state_next = ST_WB_WAIT;
            ST_WB_WAIT: if (status.mul_done) state_next = ST_Q_OUT;
            ST_Q_OUT:   if (status.out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Datapath commands
    always_comb begin
        ctrl           = '0;
        ctrl.rd_sel    = RS_PREV;
        ctrl.cap_sel   = RS_A_END;
        ctrl.mul_op    = MUL_APPEND;
        ctrl.bit_idx   = bit_reg;
        ctrl.load_item = accept;
        unique case (state_reg)
            ST_CLR:     ctrl.cnt_clear = 1'b1;
            ST_AP_RD:   ctrl.rd_en = !status.full;
            ST_AP_GO:   ctrl.mul_start = 1'b1;
            ST_AP_WR:   ctrl.app_write = 1'b1;
            ST_Q_CHK:   ctrl.pow_init = 1'b1;
            ST_Q_RD: begin
                ctrl.rd_sel  = rd_sel_t'(rd_idx_reg);
                ctrl.rd_en   = (rd_idx_reg != RD_STEPS);
                ctrl.cap_en  = (rd_idx_reg != 3'd0);
                ctrl.cap_sel = rd_sel_t'(rd_idx_reg - 3'd1);
            end
            ST_PA_GO: begin
                ctrl.mul_op    = MUL_POW_ACC;
                ctrl.mul_start = 1'b1;
            end
            ST_PA_WAIT: begin
                ctrl.mul_op = MUL_POW_ACC;
                ctrl.mul_wr = status.mul_done;
            end
            ST_PS_GO: begin
                ctrl.mul_op    = MUL_POW_SQ;
                ctrl.mul_start = 1'b1;
            end
            ST_PS_WAIT: begin
                ctrl.mul_op = MUL_POW_SQ;
                ctrl.mul_wr = status.mul_done;
            end
            ST_WA_GO: begin
                ctrl.mul_op    = MUL_WIN_A;
                ctrl.mul_start = 1'b1;
            end
            ST_WA_WAIT: begin
                ctrl.mul_op = MUL_WIN_A;
                ctrl.mul_wr = status.mul_done;
            end
            ST_WB_GO: begin
                ctrl.mul_op    = MUL_WIN_B;
                ctrl.mul_start = 1'b1;
            end
            ST_WB_WAIT: begin
                ctrl.mul_op = MUL_WIN_B;
                ctrl.mul_wr = status.mul_done;
            end
            ST_Q_OUT:   ctrl.out_load = status.out_free;
            default:    ;
        endcase
    end

endmodule

// ===== design/substring_equality_double_hash.sv =====
// ----------------------------------------------------------------------------
// substring_equality_double_hash: substring compare by two polynomial hashes
// Loads a byte string, keeps prefix hashes modulo two primes, and answers
// window equality queries.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): tuser carries the command (append, query, clear),
//   tdata the byte, the two start positions and the length. One item is
//   taken at a time; s_tready is high only while the block is idle.
//   Result stream (m_*): one transfer per query, none for append or clear.
//   An in-range query is the long operation: each modular multiply runs
//   30 bit-serial steps, and the query needs 11 squarings, up to 10
//   accumulate steps and two window scalings.
//   APB port: register 0 (address 0) holds the hash base; write it idle.
//   Reset clears the loaded length, the base (to 31) and the result
//   register. When the result receiver stalls, the result waits in the
//   output register and the next item is still taken; a further query
//   then holds in its last step until the register frees.
// ----------------------------------------------------------------------------
module substring_equality_double_hash #(
    parameter int MAX_LEN = shdh_pkg::MAX_LEN_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // char_code[7:0], start_a[18:8], start_b[29:19], length[40:30], zero pad
    input  logic [shdh_pkg::IN_TDATA_W-1:0]    s_tdata,
    // command[1:0]
    input  logic [shdh_pkg::CMD_W-1:0]         s_tuser,
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // equal[0], zero pad
    output logic [shdh_pkg::OUT_TDATA_W-1:0]   m_tdata,
    // range_error[0]
    output logic                               m_tuser,
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [shdh_pkg::APB_AW-1:0]        paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import shdh_pkg::*;

    ctrl_t   ctrl;
    status_t status;
    logic    m_equal;
    logic    cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    shdh_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .ctrl     (ctrl),
        .status   (status)
    );

    shdh_datapath #(
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_equal       (m_equal),
        .m_range_error (m_tuser),
        .cfg_we        (cfg_we),
        .cfg_addr      (paddr),
        .cfg_wdata     (pwdata),
        .cfg_rdata     (prdata),
        .ctrl          (ctrl),
        .status        (status)
    );

    assign m_tdata = {{(OUT_TDATA_W-1){1'b0}}, m_equal};

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the double-hash substring compare
// Loads byte strings over the input stream and asks window-compare queries.
// A local model keeps both prefix-hash tables and predicts every query
// verdict. Directed rows cover the corner cases, then random strings with
// periodic content are hashed under several bases. Both stream sides stall
// at random, and the base register is rewritten between phases over APB.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
    import shdh_pkg::*;

    localparam int CAP       = MAX_LEN_DEF;
    localparam int N_ITEMS   = 1950;
    localparam int N_PHASES  = 5;
    localparam int CYC_LIMIT = 6000000;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    // char_code[7:0], start_a[18:8], start_b[29:19], length[40:30], zero pad
    logic [IN_TDATA_W-1:0]  s_tdata;
    // command[1:0]
    logic [CMD_W-1:0]       s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    // equal[0], zero pad
    logic [OUT_TDATA_W-1:0] m_tdata;
    // range_error[0]
    logic                   m_tuser;
    logic                   psel, penable, pwrite;
    logic [APB_AW-1:0]      paddr;
    logic [31:0]            pwdata;
    logic [31:0]            prdata;
    logic                   pready;

    substring_equality_double_hash dut (.*);

    typedef struct {
        logic equal;
        logic range_err;
    } verdict_t;

    typedef struct {
        cmd_t        cmd;
        logic [7:0]  ch;
        logic [10:0] sa;
        logic [10:0] sb;
        logic [10:0] len;
        bit          typed;
        verdict_t    want;
    } stim_row_t;

    // model state
    logic [29:0] hash_one [CAP];
    logic [29:0] hash_two [CAP];
    logic [7:0]  text [CAP];
    int          loaded;
    logic [29:0] base_reg;

    verdict_t verdict_q[$];
    int       mismatches = 0;
    int       items_sent = 0;
    int       cycles = 0;
    bit       calm = 0;
    int       stall_left = 0;

    // clock
    initial begin
        aclk = 0;
        forever #2 aclk = ~aclk;
    end

    // run limit and calm stretches
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles % 700 == 0)
            calm <= ($urandom_range(0, 3) == 0);
        if (cycles >= CYC_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic longint unsigned mulmod(longint unsigned a, longint unsigned b,
                                               longint unsigned p);
        return (a * b) % p;
    endfunction

    function automatic longint unsigned powmod(longint unsigned b, int e,
                                               longint unsigned p);
        longint unsigned acc;
        acc = 1;
        b = b % p;
        while (e > 0) begin
            if (e & 1)
                acc = mulmod(acc, b, p);
            b = mulmod(b, b, p);
            e = e >> 1;
        end
        return acc;
    endfunction

    function automatic longint unsigned prefix(bit second, int k);
        if (k == 0 || k > CAP)
            return 0;
        return second ? hash_two[k-1] : hash_one[k-1];
    endfunction

    function automatic longint unsigned window(bit second, int st, int len,
                                               longint unsigned pw, longint unsigned p);
        longint unsigned hi, lo;
        hi = prefix(second, st + len) % p;
        lo = mulmod(pw, prefix(second, st) % p, p);
        return (hi + p - lo) % p;
    endfunction

    // apply one accepted item to the model; returns 1 if a verdict is due
    function automatic bit hash_step(cmd_t cmd, logic [7:0] ch, int sa, int sb, int len,
                                     output verdict_t v);
        longint unsigned w1, w2;
        v.equal = 0;
        v.range_err = 0;
        case (cmd)
            CMD_APPEND: begin
                if (loaded < CAP) begin
                    hash_one[loaded] = 30'((mulmod(base_reg % PRIME_ONE, prefix(0, loaded),
                                        PRIME_ONE) + ch) % PRIME_ONE);
                    hash_two[loaded] = 30'((mulmod(base_reg % PRIME_TWO, prefix(1, loaded),
                                        PRIME_TWO) + ch) % PRIME_TWO);
                    text[loaded] = ch;
                    loaded++;
                end
                return 0;
            end
            CMD_CLEAR: begin
                loaded = 0;
                return 0;
            end
            CMD_QUERY: begin
                if (sa + len > loaded || sb + len > loaded) begin
                    v.range_err = 1;
                    return 1;
                end
                w1 = powmod(base_reg, len, PRIME_ONE);
                w2 = powmod(base_reg, len, PRIME_TWO);
                v.equal = (window(0, sa, len, w1, PRIME_ONE) == window(0, sb, len, w1, PRIME_ONE))
                       && (window(1, sa, len, w2, PRIME_TWO) == window(1, sb, len, w2, PRIME_TWO));
                return 1;
            end
            default: return 0;
        endcase
    endfunction

    // one input transfer, with a random lead-in gap
    task automatic send_item(cmd_t cmd, logic [7:0] ch, logic [10:0] sa, logic [10:0] sb,
                             logic [10:0] len, bit typed = 0,
                             verdict_t want = '{0, 0});
        int gap;
        verdict_t v;
        gap = calm ? 0 : ($urandom_range(0, 9) == 0 ? $urandom_range(10, 60)
                                                   : $urandom_range(0, 2));
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= cmd;
        s_tdata  <= {7'd0, len, sb, sa, ch};
        do @(posedge aclk); while (!s_tready);
        if (hash_step(cmd, ch, sa, sb, len, v))
            verdict_q.push_back(typed ? want : v);
        items_sent++;
    endtask

    // drain results, then let a trailing append finish
    task automatic wait_idle();
        s_tvalid <= 0;
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic write_base(logic [29:0] value);
        wait_idle();
        psel    <= 1;
        penable <= 0;
        pwrite  <= 1;
        paddr   <= REG_BASE_ADDR;
        pwdata  <= 32'(value);
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel    <= 0;
        penable <= 0;
        pwrite  <= 0;
        base_reg = value;
    endtask

    // result side: random stalls and checking
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (verdict_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transfer: equal=%0b range_error=%0b",
                                 m_tdata[0], m_tuser);
                end else begin
                    verdict_t w;
                    w = verdict_q.pop_front();
                    if (m_tdata !== OUT_TDATA_W'(w.equal) || m_tuser !== w.range_err) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("verdict mismatch: expected equal=%0b range_error=%0b, got tdata=%0h tuser=%0b",
                                     w.equal, w.range_err, m_tdata, m_tuser);
                    end
                end
            end
            if (stall_left > 0) begin
                m_tready <= 0;
                stall_left <= stall_left - 1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                m_tready <= 0;
                stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200)
                                                          : $urandom_range(0, 3);
            end else begin
                m_tready <= 1;
            end
        end
    end

    // directed rows: verdicts typed only where obvious
    stim_row_t stim_rows[] = '{
        '{CMD_QUERY,  8'd0,   11'd0,    11'd0,    11'd0,    1, '{1, 0}}, // empty, zero length
        '{CMD_QUERY,  8'd0,   11'd1,    11'd0,    11'd0,    1, '{0, 1}},
        '{CMD_NONE,   8'hFF,  11'h7FF,  11'h7FF,  11'h7FF,  0, '{0, 0}}, // ignored
        '{CMD_APPEND, 8'h61,  11'd0,    11'd0,    11'd0,    0, '{0, 0}},
        '{CMD_APPEND, 8'h62,  11'h7FF,  11'h7FF,  11'h7FF,  0, '{0, 0}},
        '{CMD_APPEND, 8'h61,  11'd0,    11'd0,    11'd0,    0, '{0, 0}},
        '{CMD_APPEND, 8'h62,  11'd0,    11'd0,    11'd0,    0, '{0, 0}},
        '{CMD_APPEND, 8'hFF,  11'd0,    11'd0,    11'd0,    0, '{0, 0}},
        '{CMD_APPEND, 8'h00,  11'd0,    11'd0,    11'd0,    0, '{0, 0}},
        '{CMD_QUERY,  8'd0,   11'd0,    11'd2,    11'd2,    0, '{0, 0}},
        '{CMD_QUERY,  8'd0,   11'd0,    11'd1,    11'd1,    0, '{0, 0}},
        '{CMD_QUERY,  8'd0,   11'd4,    11'd5,    11'd1,    0, '{0, 0}},
        '{CMD_QUERY,  8'd0,   11'd1024, 11'd0,    11'd0,    1, '{0, 1}},
        '{CMD_QUERY,  8'd0,   11'd0,    11'd0,    11'h7FF,  1, '{0, 1}},
        '{CMD_QUERY,  8'd0,   11'd0,    11'h7FF,  11'd0,    1, '{0, 1}},
        '{CMD_QUERY,  8'd0,   11'd6,    11'd6,    11'd0,    1, '{1, 0}}, // end, zero length
        '{CMD_QUERY,  8'd0,   11'd0,    11'd0,    11'd6,    1, '{1, 0}},
        '{CMD_CLEAR,  8'd0,   11'd0,    11'd0,    11'd0,    0, '{0, 0}},
        '{CMD_QUERY,  8'd0,   11'd0,    11'd0,    11'd1,    1, '{0, 1}}, // cleared
        '{CMD_APPEND, 8'h00,  11'd0,    11'd0,    11'd0,    0, '{0, 0}},
        '{CMD_APPEND, 8'hFF,  11'd0,    11'd0,    11'd0,    0, '{0, 0}},
        '{CMD_QUERY,  8'd0,   11'd0,    11'd1,    11'd1,    0, '{0, 0}}
    };

    // random query over the current string, often at a period offset
    task automatic random_query(int period);
        int len, sa, sb;
        if ($urandom_range(0, 5) == 0) begin
            send_item(CMD_QUERY, 8'($urandom), 11'($urandom), 11'($urandom), 11'($urandom));
            return;
        end
        len = $urandom_range(0, loaded);
        if ($urandom_range(0, 9) == 0)
            len = len + $urandom_range(1, 4);
        sa = $urandom_range(0, (loaded > len) ? loaded - len : 0);
        sb = $urandom_range(0, (loaded > len) ? loaded - len : 0);
        if ($urandom_range(0, 1) && sa + period + len <= loaded)
            sb = sa + period * $urandom_range(1, (loaded - len - sa) / period);
        send_item(CMD_QUERY, 8'($urandom), 11'(sa), 11'(sb), 11'(len));
    endtask

    // periodic text, then a few queries
    task automatic random_segment();
        int period, n, alpha;
        logic [7:0] ch;
        period = $urandom_range(1, 12);
        alpha  = $urandom_range(0, 3) == 0 ? 256 : $urandom_range(2, 4);
        n      = $urandom_range(4, 40);
        if (loaded + n > CAP || $urandom_range(0, 11) == 0)
            send_item(CMD_CLEAR, 8'($urandom), 11'($urandom), 11'($urandom), 11'($urandom));
        repeat (n) begin
            if (loaded >= period && $urandom_range(0, 7) != 0)
                ch = text[loaded - period];
            else
                ch = (alpha == 256) ? 8'($urandom) : 8'($urandom_range(0, alpha - 1) + 8'h41);
            send_item(CMD_APPEND, ch, 11'($urandom), 11'($urandom), 11'($urandom));
        end
        repeat ($urandom_range(2, 8)) random_query(period);
        if ($urandom_range(0, 15) == 0)
            send_item(CMD_NONE, 8'($urandom), 11'($urandom), 11'($urandom), 11'($urandom));
    endtask

    initial begin
        logic [29:0] bases [N_PHASES];
        bases = '{BASE_RESET, 30'd1, 30'd1000000006, 30'($urandom_range(2, 1000000005)),
                  30'($urandom_range(2, 1000000005))};
        aresetn  = 0;
        s_tvalid = 0;
        s_tdata  = '0;
        s_tuser  = CMD_APPEND;
        m_tready = 0;
        psel     = 0;
        penable  = 0;
        pwrite   = 0;
        paddr    = '0;
        pwdata   = '0;
        loaded   = 0;
        base_reg = BASE_RESET;
        repeat (10) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        foreach (stim_rows[i])
            send_item(stim_rows[i].cmd, stim_rows[i].ch, stim_rows[i].sa, stim_rows[i].sb,
                      stim_rows[i].len, stim_rows[i].typed, stim_rows[i].want);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            // the string is kept across the base change
            if (ph > 0)
                write_base(bases[ph]);
            if (ph == 1) begin
                // fill to capacity, overflow, full-length windows
                send_item(CMD_CLEAR, 8'd0, 11'd0, 11'd0, 11'd0);
                repeat (CAP + 3)
                    send_item(CMD_APPEND, 8'($urandom_range(0, 1) + 8'h30), 11'd0,
                              11'd0, 11'd0);
                send_item(CMD_QUERY, 8'd0, 11'd0, 11'd0, 11'd1024, 1, '{1, 0});
                send_item(CMD_QUERY, 8'd0, 11'd1, 11'd0, 11'd1024, 1, '{0, 1});
                send_item(CMD_QUERY, 8'd0, 11'd1024, 11'd1024, 11'd0, 1, '{1, 0});
                repeat (4) random_query(1);
                send_item(CMD_CLEAR, 8'd0, 11'd0, 11'd0, 11'd0);
            end
            while (items_sent < N_ITEMS * (ph + 1) / N_PHASES)
                random_segment();
        end

        wait_idle();
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
